/* rtl/sqx_pkg.sv */
// shared types and constants for the bounded deque with key extract
package sqx_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int ID_W     = 31;
  localparam int HANDLE_W = 32;
  localparam int OUT_ID_W = 32;
  localparam int FILL_W   = 5;
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 72;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXTRACT    = 2'd3;

  // id reported when nothing is returned
  localparam logic [OUT_ID_W-1:0] NONE_ID = '1;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic push_front;
    logic push_back;
    logic set_overflow;
    logic set_none;
    logic pop_read;
    logic pop_take;
    logic scan_start;
    logic scan_run;
    logic scan_end;
    logic post;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic              full;
    logic              empty;
    logic              scan_idle;
    logic              out_free;
    logic [MODE_W-1:0] mode;
  } dp_status_t;

endpackage

/* rtl/sqx_ctrl.sv */
// controller state machine sequencing each request through the datapath
module sqx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sqx_pkg::dp_status_t status,
  output sqx_pkg::dp_cmd_t    cmd
);
  import sqx_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_POP_WAIT = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.mode) inside
          MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (status.full) begin
              cmd.set_overflow = 1'b1;
            end else if (status.mode == MODE_PUSH_FRONT) begin
              cmd.push_front = 1'b1;
            end else begin
              cmd.push_back = 1'b1;
            end
            state_next = ST_FINISH;
          end
          MODE_POP_FRONT: begin
            if (status.empty) begin
              cmd.set_none = 1'b1;
              state_next   = ST_FINISH;
            end else begin
              cmd.pop_read = 1'b1;
              state_next   = ST_POP_WAIT;
            end
          end
          default: begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        endcase
      end
      ST_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_SCAN: begin
        if (status.scan_idle) begin
          cmd.scan_end = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sqx_datapath.sv */
// circular entry memory, head and count, scan and compaction pipeline, result register
module sqx_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sqx_pkg::dp_cmd_t              cmd,
  output sqx_pkg::dp_status_t           status,
  input  logic [sqx_pkg::MODE_W-1:0]    s_tuser,
  input  logic [sqx_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sqx_pkg::M_DATA_W-1:0]  m_tdata
);
  import sqx_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // wrap-around pointer steps
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
  endfunction

  entry_t mem [CAPACITY];

  logic [MODE_W-1:0]   mode_q;
  logic [ID_W-1:0]     key_q;
  logic [HANDLE_W-1:0] hnd_q;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  entry_t              rdata;
  logic [AW-1:0]       rd_ptr;
  logic [AW-1:0]       lag_ptr;
  logic [AW-1:0]       prev_ptr;
  logic [CW-1:0]       rd_left;
  logic                rd_valid;
  logic                hit;
  logic                res_found;
  logic                res_ovf;
  logic [ID_W-1:0]     res_id;
  logic [HANDLE_W-1:0] res_handle;
  logic [CW:0]         tail_sum;
  logic [AW-1:0]       tail;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic                key_match;
  logic [CW+FILL_W-1:0] count_wide;
  logic [OUT_ID_W-1:0] out_id;

  // back slot position
  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(count);
  assign tail     = (tail_sum >= (CW + 1)'(CAPACITY)) ?
                    AW'(tail_sum - (CW + 1)'(CAPACITY)) : AW'(tail_sum);

  assign key_match = rd_valid && !hit && (rdata.id == key_q);

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = '{id: key_q, handle: hnd_q};
    if (cmd.push_front) begin
      wr_en   = 1'b1;
      wr_addr = ptr_dec(head);
    end else if (cmd.push_back) begin
      wr_en   = 1'b1;
    end else if (cmd.scan_run && rd_valid && hit) begin
      wr_en   = 1'b1;
      wr_addr = prev_ptr;
      wr_data = rdata;
    end
  end

  assign rd_addr = cmd.pop_read ? head : rd_ptr;

  // entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= s_tuser;
      key_q  <= s_tdata[ID_W-1:0];
      hnd_q  <= s_tdata[ID_W+HANDLE_W-1:ID_W];
    end
  end

  // list pointers and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rd_left  <= '0;
      rd_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      if (cmd.push_front) begin
        head  <= ptr_dec(head);
        count <= count + CW'(1);
      end
      if (cmd.push_back) begin
        count <= count + CW'(1);
      end
      if (cmd.pop_take) begin
        head  <= ptr_inc(head);
        count <= count - CW'(1);
      end
      if (cmd.scan_start) begin
        rd_left  <= count;
        rd_valid <= 1'b0;
        hit      <= 1'b0;
      end
      if (cmd.scan_run) begin
        rd_valid <= (rd_left != '0);
        if (rd_left != '0) begin
          rd_left <= rd_left - CW'(1);
        end
        if (key_match) begin
          hit <= 1'b1;
        end
      end
      if (cmd.scan_end && hit) begin
        count <= count - CW'(1);
      end
    end
  end

  // scan address chain
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_ptr <= head;
    end else if (cmd.scan_run) begin
      if (rd_left != '0) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      lag_ptr  <= rd_ptr;
      prev_ptr <= lag_ptr;
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (cmd.push_front || cmd.push_back || cmd.set_none || cmd.scan_start) begin
      res_found <= 1'b0;
      res_ovf   <= 1'b0;
    end else if (cmd.set_overflow) begin
      res_found <= 1'b0;
      res_ovf   <= 1'b1;
    end else if (cmd.pop_take || (cmd.scan_run && key_match)) begin
      res_found  <= 1'b1;
      res_ovf    <= 1'b0;
      res_id     <= rdata.id;
      res_handle <= rdata.handle;
    end
  end

  assign count_wide = (CW + FILL_W)'(count);
  assign out_id     = res_found ? {1'b0, res_id} : NONE_ID;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.post) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      m_tdata <= {1'b0, count_wide[FILL_W-1:0], res_ovf,
                  res_found ? res_handle : HANDLE_W'(0), out_id, res_found};
    end
  end

  // status to controller
  assign status.full      = (count == CW'(CAPACITY));
  assign status.empty     = (count == '0);
  assign status.scan_idle = (rd_left == '0) && !rd_valid;
  assign status.out_free  = !m_tvalid || m_tready;
  assign status.mode      = mode_q;

endmodule

/* rtl/stack_queue_with_extract_by_key_core.sv */
// top level of the bounded deque with push front/back, pop front and extract by id
// Usage:
//   Requests enter on the slave stream: s_tuser carries the operation (push front,
//   push back, pop front, extract by id), s_tdata the id and the handle. Every
//   request yields exactly one result on the master stream with found, returned
//   id (all ones when none), returned handle, overflow and the fill count after
//   the operation. A push onto a full list is dropped and reports overflow.
// Timing:
//   One request is worked at a time. After acceptance a push passes the execute and
//   finish states, a pop front also a pop wait state for the registered read, and
//   an extract a scan state whose length grows with the fill count before the
//   request. The next request is taken the cycle after the result is posted.
//   Extract streams every held entry once through the single read port of the entry
//   memory, comparing and closing the gap in the same pass, one entry per cycle.
// Reset and stall:
//   Reset empties the list and drops any pending result; no clearing pass is
//   needed. The result sits in an output register; a new request is taken while
//   it waits, and the next result holds until the receiver takes the current one.
module stack_queue_with_extract_by_key_core #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sqx_pkg::S_DATA_W-1:0]  s_tdata,  // key_id[30:0], handle[62:31], pad
  input  logic [sqx_pkg::MODE_W-1:0]    s_tuser,  // mode[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sqx_pkg::M_DATA_W-1:0]  m_tdata   // found[0], out_id[32:1],
                                                  // out_handle[64:33], overflow[65],
                                                  // fill_count[70:66], pad
);
  import sqx_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  sqx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and result path
  sqx_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/sqx_checker.sv */
// port-level checks for the deque core and their binding
module sqx_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sqx_pkg::M_DATA_W-1:0]  m_tdata
);
  import sqx_pkg::*;

  // a result held under stall stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // one request at a time: input closes right after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  // a result never both returns an entry and reports a dropped push
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[65]))
    else $error("found and overflow together");

  // nothing returned means id all ones and handle zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == NONE_ID) && (m_tdata[64:33] == '0))
    else $error("empty result carries data");

  // a returned id always fits in 31 bits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[32])
    else $error("returned id out of range");

endmodule

bind stack_queue_with_extract_by_key_core sqx_checker u_sqx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
